[src/mpm_pkg.sv]
// Shared types, constants and helpers of the Mandelbrot pixel membership unit.
`default_nettype none
package mpm_pkg;

    localparam int FRAC_BITS = 26;
    localparam int DIM_BITS  = 12;
    localparam int WORD_W    = 32;
    localparam int STEP_W    = 31;
    localparam int ITER_W    = 10;
    localparam int PROD_W    = DIM_BITS + STEP_W;
    localparam int SQ_W      = 2 * WORD_W;
    localparam int CFG_IW    = 3;
    localparam int Q_DEPTH   = 2;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    localparam logic [WORD_W-1:0] ORIGIN_RST  = WORD_W'(-67108864);
    localparam logic [STEP_W-1:0] STEP_RST    = STEP_W'(209715);
    localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(20);

    localparam bit FINAL_ALWAYS = (2 * FRAC_BITS >= 62);
    localparam logic [SQ_W-1:0] MEMBER_LIM =
        FINAL_ALWAYS ? '0 : (SQ_W'(4) << (2 * FRAC_BITS));

    typedef enum logic [CFG_IW-1:0] {
        CFG_ORIGIN_RE = 3'd0,
        CFG_ORIGIN_IM = 3'd1,
        CFG_STEP_RE   = 3'd2,
        CFG_STEP_IM   = 3'd3,
        CFG_MAX_ITER  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD
    } t_bk_state;

    typedef struct packed {
        logic signed [WORD_W-1:0] origin_re;
        logic signed [WORD_W-1:0] origin_im;
        logic [STEP_W-1:0]        step_re;
        logic [STEP_W-1:0]        step_im;
    } t_map_cfg;

    typedef struct packed {
        logic signed [WORD_W-1:0] cr;
        logic signed [WORD_W-1:0] ci;
    } t_cpt;

    typedef struct packed {
        logic valid;
        t_cpt data;
    } t_cpt_beat;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SQ_W-1:0] v);
        logic signed [WORD_W-1:0] r;
        if ((&v[SQ_W-1:WORD_W-1]) || !(|v[SQ_W-1:WORD_W-1])) begin
            r = v[WORD_W-1:0];
        end else if (v[SQ_W-1]) begin
            r = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[src/mpm_pix_if.sv]
// Pixel coordinate channel.
`default_nettype none
interface mpm_pix_if;
    import mpm_pkg::*;

    logic                valid;
    logic                ready;
    logic [DIM_BITS-1:0] col;
    logic [DIM_BITS-1:0] row;

    modport source (output valid, output col, output row, input ready);
    modport sink (input valid, input col, input row, output ready);
endinterface
`default_nettype wire

[src/mpm_res_if.sv]
// Membership result channel.
`default_nettype none
interface mpm_res_if;
    logic valid;
    logic ready;
    logic in_set;

    modport source (output valid, output in_set, input ready);
    modport sink (input valid, input in_set, output ready);
endinterface
`default_nettype wire

[src/mpm_front.sv]
// Front end: accept pixel beats and map them to complex points.
`default_nettype none
module mpm_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mpm_pkg::t_map_cfg i_cfg,
    mpm_pix_if.sink               i_pix,
    input  wire logic             i_q_ready,
    output mpm_pkg::t_cpt_beat    o_push
);
    import mpm_pkg::*;

    logic                     r_s1_vld;
    logic [PROD_W-1:0]        r_p_re;
    logic [PROD_W-1:0]        r_p_im;
    logic                     w_acc;
    logic signed [SQ_W-1:0]   w_sum_re;
    logic signed [SQ_W-1:0]   w_sum_im;

    assign i_pix.ready = !r_s1_vld || i_q_ready;
    assign w_acc       = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_acc) begin
            r_s1_vld <= 1'b1;
        end else if (i_q_ready) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_p_re <= PROD_W'(i_pix.col) * PROD_W'(i_cfg.step_re);
            r_p_im <= PROD_W'(i_pix.row) * PROD_W'(i_cfg.step_im);
        end
    end

    always_comb begin
        w_sum_re = SQ_W'(i_cfg.origin_re) + signed'(SQ_W'(r_p_re));
        w_sum_im = SQ_W'(i_cfg.origin_im) + signed'(SQ_W'(r_p_im));
        o_push.valid   = r_s1_vld;
        o_push.data.cr = sat_word(w_sum_re);
        o_push.data.ci = sat_word(w_sum_im);
    end

endmodule
`default_nettype wire

[src/mpm_queue.sv]
// Short point queue between the front end and the iteration engine.
`default_nettype none
module mpm_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mpm_pkg::t_cpt_beat i_push,
    output logic                   o_push_ready,
    output mpm_pkg::t_cpt_beat     o_pop,
    input  wire logic              i_pop_ready
);
    import mpm_pkg::*;

    t_cpt            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_CW-1:0] r_cnt;
    logic            w_wr;
    logic            w_rd;

    assign o_push_ready = (r_cnt != Q_CW'(Q_DEPTH));
    assign o_pop.valid  = (r_cnt != '0);
    assign o_pop.data   = r_mem[r_rd_ptr];
    assign w_wr         = i_push.valid && o_push_ready;
    assign w_rd         = o_pop.valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CW'(Q_DEPTH))
        else $error("queue fill count beyond depth");

endmodule
`default_nettype wire

[src/mpm_back.sv]
// Iteration engine: run z = z*z + c and hold the membership result.
`default_nettype none
module mpm_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [mpm_pkg::ITER_W-1:0] i_max_iter,
    input  wire mpm_pkg::t_cpt_beat        i_pop,
    output logic                           o_pop_ready,
    mpm_res_if.source                      o_res
);
    import mpm_pkg::*;

    t_bk_state                 r_state;
    t_bk_state                 n_state;
    logic signed [WORD_W-1:0]  r_cr;
    logic signed [WORD_W-1:0]  r_ci;
    logic signed [WORD_W-1:0]  r_zr;
    logic signed [WORD_W-1:0]  r_zi;
    logic [ITER_W-1:0]         r_k;
    logic signed [SQ_W-1:0]    r_p_rr;
    logic signed [SQ_W-1:0]    r_p_ii;
    logic signed [SQ_W-1:0]    r_p_ri;
    logic [SQ_W-1:0]           r_limit;
    logic                      r_out_vld;
    logic                      r_out_set;

    logic [SQ_W-1:0]           w_mag;
    logic signed [SQ_W-1:0]    w_re_sh;
    logic signed [SQ_W-1:0]    w_im_sh;
    logic signed [WORD_W-1:0]  w_re_w;
    logic signed [WORD_W-1:0]  w_im_w;
    logic signed [WORD_W-1:0]  w_zr_n;
    logic signed [WORD_W-1:0]  w_zi_n;
    logic                      w_esc;
    logic                      w_fin;
    logic                      w_done;
    logic                      w_member;
    logic                      w_out_free;
    logic                      w_pop;
    logic                      w_mul;
    logic                      w_step;
    logic                      w_lim_ld;
    logic                      w_out_ld;

    always_comb begin
        w_mag    = $unsigned(r_p_rr) + $unsigned(r_p_ii);
        w_re_sh  = (r_p_rr - r_p_ii) >>> FRAC_BITS;
        w_im_sh  = r_p_ri >>> (FRAC_BITS - 1);
        w_re_w   = sat_word(w_re_sh);
        w_im_w   = sat_word(w_im_sh);
        w_zr_n   = sat_word(SQ_W'(w_re_w) + SQ_W'(r_cr));
        w_zi_n   = sat_word(SQ_W'(w_im_w) + SQ_W'(r_ci));
        w_esc    = (r_k != '0) && (w_mag > r_limit);
        w_fin    = (r_k == i_max_iter);
        w_done   = w_esc || w_fin;
        w_member = !w_esc && (FINAL_ALWAYS || (w_mag < MEMBER_LIM));
    end

    assign w_out_free = !r_out_vld || o_res.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_pop.valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (!w_done) begin
                    n_state = ST_MUL;
                end else if (w_out_free) begin
                    n_state = i_pop.valid ? ST_MUL : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop_ready = 1'b0;
        w_mul       = 1'b0;
        w_step      = 1'b0;
        w_lim_ld    = 1'b0;
        w_out_ld    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop_ready = 1'b1;
            end
            ST_MUL: begin
                w_mul = 1'b1;
            end
            ST_UPD: begin
                w_lim_ld    = (r_k == '0);
                w_step      = !w_done;
                w_out_ld    = w_done && w_out_free;
                o_pop_ready = w_done && w_out_free;
            end
            default: begin
                o_pop_ready = 1'b0;
            end
        endcase
    end

    assign w_pop = o_pop_ready && i_pop.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_k       <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_pop) begin
                r_k <= '0;
            end else if (w_step) begin
                r_k <= r_k + 1'b1;
            end
            if (w_out_ld) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cr <= i_pop.data.cr;
            r_ci <= i_pop.data.ci;
            r_zr <= i_pop.data.cr;
            r_zi <= i_pop.data.ci;
        end else if (w_step) begin
            r_zr <= w_zr_n;
            r_zi <= w_zi_n;
        end
        if (w_mul) begin
            r_p_rr <= SQ_W'(r_zr) * SQ_W'(r_zr);
            r_p_ii <= SQ_W'(r_zi) * SQ_W'(r_zi);
            r_p_ri <= SQ_W'(r_zr) * SQ_W'(r_zi);
        end
        if (w_lim_ld) begin
            r_limit <= (w_mag[SQ_W-1] || w_mag[SQ_W-2]) ? '1 : (w_mag << 2);
        end
        if (w_out_ld) begin
            r_out_set <= w_member;
        end
    end

    assign o_res.valid  = r_out_vld;
    assign o_res.in_set = r_out_set;

    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_k <= i_max_iter))
        else $error("iteration count passed max_iter");

    a_pop_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && (r_state == ST_UPD)) |-> w_out_ld)
        else $error("next point taken before result stored");

    a_out_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_ld |-> ((r_state == ST_UPD) && w_done))
        else $error("result stored outside update pass");

    a_mul_then_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |=> (r_state == ST_UPD) && $stable(r_zr) && $stable(r_k))
        else $error("update pass lost its operands");

endmodule
`default_nettype wire

[src/mandelbrot_pixel_membership_unit.sv]
// Top level of the Mandelbrot pixel membership unit.
//
// i_pix carries one pixel (col, row) per beat; o_res returns one in_set bit
// per pixel, in order. Both channels move a beat when valid and ready are high.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; write them
// only while no pixel is in flight. Unknown indexes are ignored.
//
// The front end registers the pixel's products with the step sizes, adds the
// origin to form c and places it in a two-entry queue. The iteration engine
// takes each iteration through ST_MUL (the three 32x32 multipliers) and then
// ST_UPD (the update and escape compare), plus a final ST_MUL/ST_UPD pass
// for the closing magnitude; a point that escapes early finishes sooner.
//
// Synchronous active-low reset empties the pipeline and restores the default
// view and max_iter = 20. A stalled o_res holds its result; the engine then
// finishes its current pixel and waits, and the queue and front end keep
// taking pixels until they fill, after which i_pix.ready drops.
`default_nettype none
module mandelbrot_pixel_membership_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    mpm_pix_if.sink                         i_pix,
    mpm_res_if.source                       o_res,
    input  wire logic                       i_cfg_we,
    input  wire logic [mpm_pkg::CFG_IW-1:0] i_cfg_idx,
    input  wire logic [mpm_pkg::WORD_W-1:0] i_cfg_data
);
    import mpm_pkg::*;

    t_map_cfg          r_map;
    logic [ITER_W-1:0] r_max_iter;
    t_cpt_beat         w_push;
    t_cpt_beat         w_pop;
    logic              w_push_ready;
    logic              w_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map.origin_re <= ORIGIN_RST;
            r_map.origin_im <= ORIGIN_RST;
            r_map.step_re   <= STEP_RST;
            r_map.step_im   <= STEP_RST;
            r_max_iter      <= MAX_ITER_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_RE: r_map.origin_re <= i_cfg_data;
                CFG_ORIGIN_IM: r_map.origin_im <= i_cfg_data;
                CFG_STEP_RE:   r_map.step_re   <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_IM:   r_map.step_im   <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_ITER:  r_max_iter      <= i_cfg_data[ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mpm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_map),
        .i_pix     (i_pix),
        .i_q_ready (w_push_ready),
        .o_push    (w_push)
    );

    mpm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .o_pop        (w_pop),
        .i_pop_ready  (w_pop_ready)
    );

    mpm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_iter  (r_max_iter),
        .i_pop       (w_pop),
        .o_pop_ready (w_pop_ready),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire
